/* hw/rtl/hcrg_pkg.sv */
package hcrg_pkg;

    localparam int SEED_BYTES_DEF = 32;
    localparam int BITS_PER_BYTE  = 8;
    localparam int ROUNDS         = 64;

    localparam logic [1:0] MODE_WORD = 2'd0;
    localparam logic [1:0] MODE_BYTE = 2'd1;
    localparam logic [1:0] MODE_GEN  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [31:0] H0_INIT = 32'h6a09e667;

    // initial hash value
    function automatic logic [255:0] init_h();
        return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // controller to datapath commands
    typedef struct packed {
        logic word_seed;
        logic byte_load;
        logic hash_start;
        logic round_step;
        logic finish;
    } hcrg_cmd_t;

endpackage

/* hw/rtl/hcrg_ctrl.sv */
module hcrg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          mode,
    output logic                m_tvalid,
    input  logic                m_tready,
    output hcrg_pkg::hcrg_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_OUT   = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] rnd_reg, rnd_next;
    logic       acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    cmd.word_seed  = (mode == hcrg_pkg::MODE_WORD);
                    cmd.byte_load  = (mode == hcrg_pkg::MODE_BYTE);
                    cmd.hash_start = (mode == hcrg_pkg::MODE_GEN);
                    if (mode == hcrg_pkg::MODE_GEN) begin
                        state_next = ST_ROUND;
                        rnd_next   = '0;
                    end
                end
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                rnd_next       = rnd_reg + 6'd1;
                if (rnd_reg == 6'(hcrg_pkg::ROUNDS - 1)) begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

endmodule

/* hw/rtl/hcrg_dp.sv */
module hcrg_dp #(
    parameter int SEED_BYTES = hcrg_pkg::SEED_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  hcrg_pkg::hcrg_cmd_t cmd,
    input  logic [31:0]         load_value,
    input  logic                last_byte,
    output logic [31:0]         random_word
);

    localparam int          POS_W  = 6;
    localparam logic [15:0] BITLEN = 16'(SEED_BYTES * hcrg_pkg::BITS_PER_BYTE);

    logic [7:0]       seed_reg [SEED_BYTES];
    logic [7:0]       seed_next[SEED_BYTES];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      w_reg [16];
    logic [31:0]      v_reg [8];
    logic [5:0]       k_idx_reg;
    logic [31:0]      out_reg;
    logic [7:0]       blk  [64];
    logic [31:0]      s0, s1, wnew, t1, t2, ss1, ss0, ch, maj;
    logic [POS_W-1:0] pos_inc;
    logic [7:0]       pad;
    logic             carry;

    // fibonacci number modulo 256, f(0) = 0, f(1) = 1
    function automatic logic [7:0] fib8(input int n);
        logic [7:0] a, b, t;
        a = 8'd0;
        b = 8'd1;
        for (int j = 0; j < n; j++) begin
            t = a + b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    assign random_word = out_reg;

    // message block: store, 0x80 mark, zeros, bit length
    always_comb begin
        for (int i = 0; i < 64; i++) begin
            if (i < SEED_BYTES)       blk[i] = seed_reg[i];
            else if (i == SEED_BYTES) blk[i] = 8'h80;
            else if (i == 62)         blk[i] = BITLEN[15:8];
            else if (i == 63)         blk[i] = BITLEN[7:0];
            else                      blk[i] = 8'h00;
        end
    end

    // store update: seeding and counter increment
    always_comb begin
        pos_next = pos_reg;
        pos_inc  = pos_reg;
        pad      = '0;
        carry    = 1'b1;
        for (int i = 0; i < SEED_BYTES; i++) seed_next[i] = seed_reg[i];
        if (cmd.word_seed) begin
            for (int i = 0; i < 4; i++) seed_next[i] = load_value[8*i +: 8];
            // later bytes are fibonacci-weighted sums of bytes 3 and 2
            for (int i = 4; i < SEED_BYTES; i++)
                seed_next[i] = fib8(i - 2) * load_value[31:24]
                             + fib8(i - 3) * load_value[23:16];
            pos_next = '0;
        end else if (cmd.byte_load) begin
            if (pos_reg < POS_W'(SEED_BYTES)) begin
                for (int i = 0; i < SEED_BYTES; i++)
                    if (pos_reg == POS_W'(i)) seed_next[i] = load_value[7:0];
                pos_inc = pos_reg + 1'b1;
            end
            pos_next = pos_inc;
            if (last_byte) begin
                pad = 8'(SEED_BYTES) - 8'(pos_inc);
                for (int i = 0; i < SEED_BYTES; i++)
                    if (POS_W'(i) >= pos_inc) seed_next[i] = pad;
                pos_next = '0;
            end
        end else if (cmd.finish) begin
            for (int i = 0; i < SEED_BYTES; i++) begin
                seed_next[i] = seed_reg[i] + 8'(carry);
                carry        = carry && (seed_reg[i] == 8'hff);
            end
        end
    end

    // shared round unit with a rolling 16-word schedule window
    always_comb begin
        s0   = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
             ^ (w_reg[1] >> 3);
        s1   = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
             ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        ss1  = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
             ^ {v_reg[4][24:0], v_reg[4][31:25]};
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + ss1 + ch + hcrg_pkg::round_k(k_idx_reg) + w_reg[0];
        ss0  = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
             ^ {v_reg[0][21:0], v_reg[0][31:22]};
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = ss0 + maj;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SEED_BYTES; i++) seed_reg[i] <= '0;
            pos_reg <= '0;
        end else begin
            for (int i = 0; i < SEED_BYTES; i++) seed_reg[i] <= seed_next[i];
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hash_start) begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 0; i < 8; i++)
                v_reg[i] <= hcrg_pkg::init_h()[255-32*i -: 32];
            k_idx_reg <= '0;
        end else if (cmd.round_step) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            k_idx_reg <= k_idx_reg + 6'd1;
        end
        if (cmd.finish) out_reg <= hcrg_pkg::H0_INIT + t1 + t2;
    end

endmodule

/* hw/rtl/hash_counter_random_generator.sv */
// counter-mode random generator: a seed store (cleared at reset) is seeded from a word
// (mode 0) or loaded byte by byte with padding on the last byte (mode 1); mode 2 returns
// the first four bytes of the sha-256 digest of the store, big-endian, then increments
// the store as a little-endian counter. seeding beats give no result; a generate beat runs
// the 64 rounds of the single shared compression round unit, then waits for the output
// handshake. mode 3 is accepted and ignored.
module hash_counter_random_generator #(
    parameter int SEED_BYTES = hcrg_pkg::SEED_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[1:0], load_value[33:2], zero fill
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // random_word
);

    hcrg_pkg::hcrg_cmd_t cmd;

    // controller: handshake and round sequencing
    hcrg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tdata[1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath: seed store, schedule window and round unit
    hcrg_dp #(.SEED_BYTES(SEED_BYTES)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .load_value  (s_tdata[33:2]),
        .last_byte   (s_tlast),
        .random_word (m_tdata)
    );

endmodule
